[src/xyzrgb_pkg.sv]
// shared types, constants and helpers for the xyz to rgb pixel converter
package xyzrgb_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int OUT_W         = 8;
  localparam int ACT_W         = 2;
  localparam int NUM_CH        = 3;
  localparam int TABLE_ENTRIES = 4096;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

  // matrix arithmetic widths
  localparam int COEF_W    = 15;
  localparam int LIN_W     = SAMPLE_W + 1;
  localparam int PROD_W    = COEF_W + LIN_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_BITS = 12;

  typedef enum logic [ACT_W-1:0] {
    ACT_CONVERT   = 2'd0,
    ACT_IN_GAMMA  = 2'd1,
    ACT_OUT_GAMMA = 2'd2
  } action_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] chan_vec_t;

  // xyz to srgb coefficients scaled by 4095, rows are r, g, b
  localparam coef_t COEF [NUM_CH][NUM_CH] = '{
    '{ 15'sd13270, -15'sd6295, -15'sd2041},
    '{-15'sd3969,   15'sd7682,  15'sd170 },
    '{ 15'sd228,   -15'sd835,   15'sd4329}
  };

  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } mtx_ctl_t;

  function automatic logic in_table(input logic [SAMPLE_W-1:0] idx);
    return (32'(idx) < 32'(TABLE_ENTRIES));
  endfunction

endpackage

[src/xyzrgb_ram.sv]
// generic single write port, single read port ram with registered read
module xyzrgb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/xyzrgb_matrix.sv]
// 3x3 color matrix: registered products, registered sums, shift and clamp
module xyzrgb_matrix (
  input  logic                 clk_i,
  input  xyzrgb_pkg::mtx_ctl_t ctl_i,
  input  xyzrgb_pkg::chan_vec_t lin_i,
  output xyzrgb_pkg::chan_vec_t chan_o
);

  logic signed [xyzrgb_pkg::PROD_W-1:0] prod_d [xyzrgb_pkg::NUM_CH][xyzrgb_pkg::NUM_CH];
  logic signed [xyzrgb_pkg::PROD_W-1:0] prod_q [xyzrgb_pkg::NUM_CH][xyzrgb_pkg::NUM_CH];
  logic signed [xyzrgb_pkg::SUM_W-1:0]  sum_d  [xyzrgb_pkg::NUM_CH];
  logic signed [xyzrgb_pkg::SUM_W-1:0]  sum_q  [xyzrgb_pkg::NUM_CH];

  always_comb begin
    for (int r = 0; r < xyzrgb_pkg::NUM_CH; r++) begin
      for (int k = 0; k < xyzrgb_pkg::NUM_CH; k++) begin
        prod_d[r][k] = xyzrgb_pkg::PROD_W'(xyzrgb_pkg::COEF[r][k]) *
                       xyzrgb_pkg::PROD_W'($signed({1'b0, lin_i[k]}));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < xyzrgb_pkg::NUM_CH; r++) begin
      sum_d[r] = xyzrgb_pkg::SUM_W'(prod_q[r][0]) + xyzrgb_pkg::SUM_W'(prod_q[r][1]) +
                 xyzrgb_pkg::SUM_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      prod_q <= prod_d;
    end
    if (ctl_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  // floor shift then clamp: negative gives zero, any bit above the channel saturates
  always_comb begin
    for (int r = 0; r < xyzrgb_pkg::NUM_CH; r++) begin
      if (sum_q[r][xyzrgb_pkg::SUM_W-1]) begin
        chan_o[r] = '0;
      end else if (|sum_q[r][xyzrgb_pkg::SUM_W-2:xyzrgb_pkg::FRAC_BITS+xyzrgb_pkg::SAMPLE_W]) begin
        chan_o[r] = '1;
      end else begin
        chan_o[r] = sum_q[r][xyzrgb_pkg::FRAC_BITS+xyzrgb_pkg::SAMPLE_W-1:xyzrgb_pkg::FRAC_BITS];
      end
    end
  end

endmodule

[src/xyz_to_rgb_pixel_converter.sv]
// top level of the xyz to rgb pixel converter
//
// input channel (in_valid_i / in_ready_o) carries one transaction per item:
// action 0 converts the x, y, z samples, action 1 writes an input gamma
// entry, action 2 writes an output gamma entry, action 3 is dropped.
// output channel (out_valid_o / out_ready_i) carries one 8-bit r, g, b
// transaction per convert item, in input order.
// both gamma tables must be loaded before any entry is looked up; each is
// held as three ram copies so that all three channels read in the same cycle.
// a convert goes input lookup, products, sums, output lookup, each held in its
// own register in that order; out_valid_o follows the output lookup stage.
// throughput is one transaction per cycle while out_ready_i is high; four
// register stages each advance independently, so bubbles collapse while the
// receiver stalls and input is accepted until every stage holds an item.
// output gamma writes travel down the pipeline and land at the output lookup
// stage, so they stay ordered against converts already in flight.
// reset empties the pipeline; table contents are kept undefined, no clearing
// pass runs and the block is ready as soon as reset is released.
module xyz_to_rgb_pixel_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [xyzrgb_pkg::ACT_W-1:0]      action_i,
  input  logic [xyzrgb_pkg::SAMPLE_W-1:0]   x_sample_i,
  input  logic [xyzrgb_pkg::SAMPLE_W-1:0]   y_sample_i,
  input  logic [xyzrgb_pkg::SAMPLE_W-1:0]   z_sample_i,
  input  logic [xyzrgb_pkg::SAMPLE_W-1:0]   table_index_i,
  input  logic [xyzrgb_pkg::SAMPLE_W-1:0]   table_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [xyzrgb_pkg::OUT_W-1:0]      red_o,
  output logic [xyzrgb_pkg::OUT_W-1:0]      green_o,
  output logic [xyzrgb_pkg::OUT_W-1:0]      blue_o
);

  xyzrgb_pkg::action_e   act;
  xyzrgb_pkg::chan_vec_t smp;
  xyzrgb_pkg::chan_vec_t ig_rdata;
  xyzrgb_pkg::chan_vec_t og_rdata;
  xyzrgb_pkg::chan_vec_t lin;
  xyzrgb_pkg::chan_vec_t chan;
  xyzrgb_pkg::mtx_ctl_t  mtx_ctl;

  logic is_conv, is_in_wr, is_out_wr;
  logic acc, ld_s1, ig_we;
  logic s1_go, s2_go, s3_go, s1_free, s2_free, s3_free, s4_free;
  logic ld_s4, og_we;

  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d, s4_v_q, s4_v_d;
  logic s1_wr_q, s2_wr_q, s3_wr_q;
  logic [xyzrgb_pkg::SAMPLE_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic [xyzrgb_pkg::SAMPLE_W-1:0] s1_val_q, s2_val_q, s3_val_q;
  logic [xyzrgb_pkg::NUM_CH-1:0]   s1_rng_q, s4_rng_q;
  logic [xyzrgb_pkg::NUM_CH-1:0]   smp_rng, chan_rng;

  assign act = xyzrgb_pkg::action_e'(action_i);
  assign smp = {z_sample_i, y_sample_i, x_sample_i};

  always_comb begin
    is_conv   = 1'b0;
    is_in_wr  = 1'b0;
    is_out_wr = 1'b0;
    case (act)
      xyzrgb_pkg::ACT_CONVERT:   is_conv   = 1'b1;
      xyzrgb_pkg::ACT_IN_GAMMA:  is_in_wr  = 1'b1;
      xyzrgb_pkg::ACT_OUT_GAMMA: is_out_wr = 1'b1;
      default: ;
    endcase
  end

  // stage flow: write items for the output table leave at stage 3 without a slot
  assign s4_free = ~s4_v_q | out_ready_i;
  assign s3_go   = s3_v_q & (s3_wr_q | s4_free);
  assign s3_free = ~s3_v_q | s3_go;
  assign s2_go   = s2_v_q & s3_free;
  assign s2_free = ~s2_v_q | s2_go;
  assign s1_go   = s1_v_q & s2_free;
  assign s1_free = ~s1_v_q | s1_go;

  assign in_ready_o = s1_free;
  assign acc        = in_valid_i & in_ready_o;
  assign ld_s1      = acc & (is_conv | is_out_wr);
  assign ig_we      = acc & is_in_wr & xyzrgb_pkg::in_table(table_index_i);
  assign ld_s4      = s3_go & ~s3_wr_q;
  assign og_we      = s3_go & s3_wr_q & xyzrgb_pkg::in_table(s3_idx_q);

  assign s1_v_d = (s1_v_q & ~s1_go) | ld_s1;
  assign s2_v_d = (s2_v_q & ~s2_go) | s1_go;
  assign s3_v_d = (s3_v_q & ~s3_go) | s2_go;
  assign s4_v_d = (s4_v_q & ~out_ready_i) | ld_s4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
      s4_v_q <= s4_v_d;
    end
  end

  always_comb begin
    for (int c = 0; c < xyzrgb_pkg::NUM_CH; c++) begin
      smp_rng[c]  = xyzrgb_pkg::in_table(smp[c]);
      chan_rng[c] = xyzrgb_pkg::in_table(chan[c]);
      lin[c]      = s1_rng_q[c] ? ig_rdata[c] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_s1) begin
      s1_wr_q  <= is_out_wr;
      s1_idx_q <= table_index_i;
      s1_val_q <= table_value_i;
      s1_rng_q <= smp_rng;
    end
    if (s1_go) begin
      s2_wr_q  <= s1_wr_q;
      s2_idx_q <= s1_idx_q;
      s2_val_q <= s1_val_q;
    end
    if (s2_go) begin
      s3_wr_q  <= s2_wr_q;
      s3_idx_q <= s2_idx_q;
      s3_val_q <= s2_val_q;
    end
    if (ld_s4) begin
      s4_rng_q <= chan_rng;
    end
  end

  assign mtx_ctl.ld_prod = s1_go;
  assign mtx_ctl.ld_sum  = s2_go;

  xyzrgb_matrix u_matrix (
    .clk_i  (clk_i),
    .ctl_i  (mtx_ctl),
    .lin_i  (lin),
    .chan_o (chan)
  );

  for (genvar c = 0; c < xyzrgb_pkg::NUM_CH; c++) begin : g_ch
    xyzrgb_ram #(
      .WIDTH (xyzrgb_pkg::SAMPLE_W),
      .DEPTH (xyzrgb_pkg::TABLE_ENTRIES)
    ) u_in_gamma (
      .clk_i   (clk_i),
      .we_i    (ig_we),
      .waddr_i (xyzrgb_pkg::TBL_AW'(table_index_i)),
      .wdata_i (table_value_i),
      .re_i    (acc & is_conv),
      .raddr_i (xyzrgb_pkg::TBL_AW'(smp[c])),
      .rdata_o (ig_rdata[c])
    );

    xyzrgb_ram #(
      .WIDTH (xyzrgb_pkg::SAMPLE_W),
      .DEPTH (xyzrgb_pkg::TABLE_ENTRIES)
    ) u_out_gamma (
      .clk_i   (clk_i),
      .we_i    (og_we),
      .waddr_i (xyzrgb_pkg::TBL_AW'(s3_idx_q)),
      .wdata_i (s3_val_q),
      .re_i    (ld_s4),
      .raddr_i (xyzrgb_pkg::TBL_AW'(chan[c])),
      .rdata_o (og_rdata[c])
    );
  end

  assign out_valid_o = s4_v_q;
  assign red_o   = s4_rng_q[0] ?
                   og_rdata[0][xyzrgb_pkg::SAMPLE_W-1 -: xyzrgb_pkg::OUT_W] : '0;
  assign green_o = s4_rng_q[1] ?
                   og_rdata[1][xyzrgb_pkg::SAMPLE_W-1 -: xyzrgb_pkg::OUT_W] : '0;
  assign blue_o  = s4_rng_q[2] ?
                   og_rdata[2][xyzrgb_pkg::SAMPLE_W-1 -: xyzrgb_pkg::OUT_W] : '0;

endmodule
